// File: rtl/lif_neuron_exp_synapse_step_macros.svh
// assertion macros for the lif neuron step block
// used by the checker; expects clk_i and rst_ni in scope
`ifndef LIF_NEURON_EXP_SYNAPSE_STEP_MACROS_SVH
`define LIF_NEURON_EXP_SYNAPSE_STEP_MACROS_SVH

// checked outside reset
`define LNES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define LNES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/lnes_pkg.sv
// shared types, constants and helpers of the lif neuron step block
// no dependencies
`default_nettype none

package lnes_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned DECAY_W      = 16;
  localparam int unsigned REFRAC_W     = 10;
  localparam int unsigned REFRAC_STEPS = 2;
  localparam int unsigned CMD_DEPTH    = 4;
  localparam int unsigned RES_DEPTH    = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned SUM_W        = 51;

  // input op codes
  localparam logic [1:0] OP_SYN   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_MEM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_EXC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_EXC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_INH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POT = 3'd7;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    CMD_EXC,
    CMD_INH,
    CMD_TICK,
    CMD_START
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_W-1:0]     index;
    logic [DATA_W-1:0]        data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] potential;
    logic signed [DATA_W-1:0] exc;
    logic signed [DATA_W-1:0] inh;
    logic                     fired;
  } res_t;

  typedef struct packed {
    logic push;
    res_t data;
  } res_req_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lif_neuron_exp_synapse_step.sv
// Leaky integrate-and-fire neuron with exponential synaptic currents. Input words
// enter a command queue (CMD_DEPTH deep) and are executed in order by the back end;
// one result word per tick leaves through a result queue (RES_DEPTH deep). In the
// back end a synaptic or start word, or a tick during the refractory period, is
// executed directly; any other tick first registers the products of the neuron
// state, then sums them, compares to the threshold and writes back, and the next
// word needs that updated state. A tick waits while the result queue is full.
// Configuration writes are always ready.
// depends on lnes_pkg, lnes_front, lnes_core and lnes_fifo
`default_nettype none

module lif_neuron_exp_synapse_step #(
  parameter int unsigned REFRAC_STEPS = lnes_pkg::REFRAC_STEPS,
  parameter int unsigned CMD_DEPTH    = lnes_pkg::CMD_DEPTH,
  parameter int unsigned RES_DEPTH    = lnes_pkg::RES_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          op_i,
  input  logic signed [lnes_pkg::DATA_W-1:0]  value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lnes_pkg::DATA_W-1:0]  membrane_potential_o,
  output logic signed [lnes_pkg::DATA_W-1:0]  exc_current_o,
  output logic signed [lnes_pkg::DATA_W-1:0]  inh_current_o,
  output logic                                fired_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lnes_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lnes_pkg::DATA_W-1:0]         cfg_data_i
);

  lnes_pkg::front_req_t req;
  lnes_pkg::cfg_wr_t    cfg;
  lnes_pkg::res_req_t   res_req;
  lnes_pkg::res_t       res_head;
  logic                 cmd_pop;
  logic                 res_full;
  logic [$bits(lnes_pkg::res_t)-1:0] res_bits;

  assign cfg_ready_o = 1'b1;
  assign cfg.we      = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  lnes_front #(
    .CMD_DEPTH (CMD_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .op_i      (op_i),
    .value_i   (value_i),
    .cmd_pop_i (cmd_pop),
    .req_o     (req)
  );

  lnes_core #(
    .REFRAC_STEPS (REFRAC_STEPS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .req_i      (req),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_o      (res_req)
  );

  lnes_fifo #(
    .WIDTH ($bits(lnes_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_req.push),
    .data_i  (res_req.data),
    .pop_i   (pop),
    .data_o  (res_bits),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign res_head             = lnes_pkg::res_t'(res_bits);
  assign membrane_potential_o = res_head.potential;
  assign exc_current_o        = res_head.exc;
  assign inh_current_o        = res_head.inh;
  assign fired_o              = res_head.fired;

endmodule

`default_nettype wire

// File: rtl/lnes_fifo.sv
// small first-in first-out queue of words
// generic, no package dependency
`default_nettype none

module lnes_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lnes_front.sv
// front end: accepts input words, sorts them into commands, queues them
// depends on lnes_pkg and lnes_fifo
`default_nettype none

module lnes_front #(
  parameter int unsigned CMD_DEPTH = lnes_pkg::CMD_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         op_i,
  input  logic signed [lnes_pkg::DATA_W-1:0] value_i,
  input  logic                               cmd_pop_i,
  output lnes_pkg::front_req_t               req_o
);

  lnes_pkg::cmd_t cmd_in, cmd_head;
  logic           keep;
  logic           q_empty;
  logic [$bits(lnes_pkg::cmd_t)-1:0] head_bits;

  // op 3 is taken and dropped
  always_comb begin
    cmd_in.value = value_i;
    cmd_in.kind  = lnes_pkg::CMD_TICK;
    keep         = 1'b1;
    unique case (op_i)
      lnes_pkg::OP_SYN:   cmd_in.kind = value_i[lnes_pkg::DATA_W-1] ? lnes_pkg::CMD_INH
                                                                    : lnes_pkg::CMD_EXC;
      lnes_pkg::OP_TICK:  cmd_in.kind = lnes_pkg::CMD_TICK;
      lnes_pkg::OP_START: cmd_in.kind = lnes_pkg::CMD_START;
      default:            keep        = 1'b0;
    endcase
  end

  lnes_fifo #(
    .WIDTH ($bits(lnes_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop_i),
    .data_o  (head_bits),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign cmd_head    = lnes_pkg::cmd_t'(head_bits);
  assign req_o.valid = !q_empty;
  assign req_o.cmd   = cmd_head;

endmodule

`default_nettype wire

// File: rtl/lnes_core.sv
// back end: configuration registers, neuron state and the tick datapath
// depends on lnes_pkg
`default_nettype none

module lnes_core #(
  parameter int unsigned REFRAC_STEPS = lnes_pkg::REFRAC_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lnes_pkg::cfg_wr_t    cfg_i,
  input  lnes_pkg::front_req_t req_i,
  output logic                 cmd_pop_o,
  input  logic                 res_full_i,
  output lnes_pkg::res_req_t   res_o
);

  localparam int unsigned DW = lnes_pkg::DATA_W;
  localparam int unsigned RW = lnes_pkg::REFRAC_W;
  localparam int unsigned SW = lnes_pkg::SUM_W;
  localparam logic [RW-1:0] REFRAC_INIT = RW'(REFRAC_STEPS);
  localparam logic [RW-1:0] REFRAC_LOAD = (REFRAC_STEPS > 0) ? RW'(REFRAC_STEPS - 1) : '0;

  logic [lnes_pkg::DECAY_W-1:0] decay_mem_q, decay_exc_q, decay_inh_q;
  logic signed [DW-1:0] gain_exc_q, gain_inh_q, bias_q, thr_q, rst_pot_q;

  logic signed [DW-1:0] pot_q, pot_d, cexc_q, cexc_d, cinh_q, cinh_d;
  logic signed [DW-1:0] aexc_q, aexc_d, ainh_q, ainh_d;
  logic [RW-1:0]        refr_q, refr_d;
  logic                 busy_q, busy_d;

  logic signed [48:0] p_mem_q, p_dexc_q, p_dinh_q;
  logic signed [63:0] p_gexc_q, p_ginh_q;
  logic               mul_en;

  logic signed [SW-1:0] sum;
  logic signed [DW-1:0] pot_new, dexc, dinh, cexc_acc, cinh_acc;
  logic                 fire;

  // tick write-back: sum of floored terms, threshold, current update
  always_comb begin
    sum = SW'($signed(p_mem_q[48:16])) + SW'($signed(p_gexc_q[63:16]))
        + SW'($signed(p_ginh_q[63:16])) + SW'(bias_q);
    pot_new  = lnes_pkg::sat32(sum);
    fire     = (pot_new >= thr_q);
    dexc     = $signed(p_dexc_q[47:16]);
    dinh     = $signed(p_dinh_q[47:16]);
    cexc_acc = lnes_pkg::sat32(SW'(dexc) + SW'(aexc_q));
    cinh_acc = lnes_pkg::sat32(SW'(dinh) + SW'(ainh_q));
  end

  always_comb begin
    pot_d      = pot_q;
    cexc_d     = cexc_q;
    cinh_d     = cinh_q;
    aexc_d     = aexc_q;
    ainh_d     = ainh_q;
    refr_d     = refr_q;
    busy_d     = 1'b0;
    mul_en     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_o.push = 1'b0;
    res_o.data = '{potential: pot_q, exc: cexc_q, inh: cinh_q, fired: 1'b0};
    if (busy_q) begin
      cmd_pop_o  = 1'b1;
      res_o.push = 1'b1;
      aexc_d     = '0;
      ainh_d     = '0;
      if (fire) begin
        pot_d  = rst_pot_q;
        cexc_d = dexc;
        cinh_d = dinh;
        refr_d = REFRAC_LOAD;
      end else begin
        pot_d  = pot_new;
        cexc_d = cexc_acc;
        cinh_d = cinh_acc;
      end
      res_o.data = '{potential: pot_d, exc: cexc_d, inh: cinh_d, fired: fire};
    end else if (req_i.valid) begin
      unique case (req_i.cmd.kind)
        lnes_pkg::CMD_EXC: begin
          aexc_d    = lnes_pkg::sat32(SW'(aexc_q) + SW'(req_i.cmd.value));
          cmd_pop_o = 1'b1;
        end
        lnes_pkg::CMD_INH: begin
          ainh_d    = lnes_pkg::sat32(SW'(ainh_q) + SW'(req_i.cmd.value));
          cmd_pop_o = 1'b1;
        end
        lnes_pkg::CMD_START: begin
          pot_d     = req_i.cmd.value;
          refr_d    = REFRAC_INIT;
          cexc_d    = '0;
          cinh_d    = '0;
          cmd_pop_o = 1'b1;
        end
        lnes_pkg::CMD_TICK: begin
          if (!res_full_i) begin
            if (refr_q != '0) begin
              refr_d     = refr_q - RW'(1);
              aexc_d     = '0;
              ainh_d     = '0;
              cmd_pop_o  = 1'b1;
              res_o.push = 1'b1;
            end else begin
              busy_d = 1'b1;
              mul_en = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_mem_q  <= 49'($signed({1'b0, decay_mem_q})) * 49'(pot_q);
      p_dexc_q <= 49'($signed({1'b0, decay_exc_q})) * 49'(cexc_q);
      p_dinh_q <= 49'($signed({1'b0, decay_inh_q})) * 49'(cinh_q);
      p_gexc_q <= 64'(gain_exc_q) * 64'(cexc_q);
      p_ginh_q <= 64'(gain_inh_q) * 64'(cinh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_q  <= '0;
      cexc_q <= '0;
      cinh_q <= '0;
      aexc_q <= '0;
      ainh_q <= '0;
      refr_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pot_q  <= pot_d;
      cexc_q <= cexc_d;
      cinh_q <= cinh_d;
      aexc_q <= aexc_d;
      ainh_q <= ainh_d;
      refr_q <= refr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_mem_q <= '0;
      gain_exc_q  <= '0;
      gain_inh_q  <= '0;
      bias_q      <= '0;
      decay_exc_q <= '0;
      decay_inh_q <= '0;
      thr_q       <= '0;
      rst_pot_q   <= '0;
    end else if (cfg_i.we) begin
      unique case (cfg_i.index)
        lnes_pkg::REG_DECAY_MEM: decay_mem_q <= cfg_i.data[lnes_pkg::DECAY_W-1:0];
        lnes_pkg::REG_GAIN_EXC:  gain_exc_q  <= $signed(cfg_i.data);
        lnes_pkg::REG_GAIN_INH:  gain_inh_q  <= $signed(cfg_i.data);
        lnes_pkg::REG_BIAS:      bias_q      <= $signed(cfg_i.data);
        lnes_pkg::REG_DECAY_EXC: decay_exc_q <= cfg_i.data[lnes_pkg::DECAY_W-1:0];
        lnes_pkg::REG_DECAY_INH: decay_inh_q <= cfg_i.data[lnes_pkg::DECAY_W-1:0];
        lnes_pkg::REG_THRESHOLD: thr_q       <= $signed(cfg_i.data);
        lnes_pkg::REG_RESET_POT: rst_pot_q   <= $signed(cfg_i.data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lnes_checker.sv
// port-level checks for the lif neuron step block, bound to its top level
// depends on lnes_pkg and lif_neuron_exp_synapse_step_macros.svh
`default_nettype none
`include "lif_neuron_exp_synapse_step_macros.svh"

module lnes_checker #(
  parameter int unsigned REFRAC_STEPS = lnes_pkg::REFRAC_STEPS
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic [1:0]                         op_i,
  input logic                               empty,
  input logic                               pop,
  input logic signed [lnes_pkg::DATA_W-1:0] membrane_potential_o,
  input logic                               fired_o
);

  logic [7:0] pend_q, pend_d;
  logic       last_fired_q;
  logic       tick_in, res_out;

  assign tick_in = push && !full && (op_i == lnes_pkg::OP_TICK);
  assign res_out = pop && !empty;

  // ticks taken whose word has not left yet
  always_comb begin
    pend_d = pend_q;
    unique case ({tick_in, res_out})
      2'b10:   pend_d = pend_q + 8'd1;
      2'b01:   pend_d = pend_q - 8'd1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_fired_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (res_out) begin
        last_fired_q <= fired_o;
      end
    end
  end

  `LNES_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (empty && !full), "queues not clear in reset")
  `LNES_ASSERT(a_res_hold, (!empty && !pop) |=> (!empty && $stable(membrane_potential_o) && $stable(fired_o)), "waiting result word changed")
  `LNES_ASSERT(a_no_extra, (pend_q == 8'd0) |-> empty, "result word without a tick")
  `LNES_ASSERT(a_refrac, ((REFRAC_STEPS >= 2) && last_fired_q && res_out) |-> !fired_o, "fired during refractory period")

endmodule

bind lif_neuron_exp_synapse_step lnes_checker #(
  .REFRAC_STEPS (REFRAC_STEPS)
) u_lnes_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .push                 (push),
  .full                 (full),
  .op_i                 (op_i),
  .empty                (empty),
  .pop                  (pop),
  .membrane_potential_o (membrane_potential_o),
  .fired_o              (fired_o)
);

`default_nettype wire
